/* hw/rtl/mfgb_pkg.sv */
// Shared types and constants for the monochrome frame buffer glyph blitter.
package mfgb_pkg;

   // Input transaction command codes.
   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_GLYPH   = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;
   localparam logic [1:0] CMD_REFRESH = 2'd3;

   // Panel command bytes sent at the head of every page.
   localparam logic [7:0] PANEL_PAGE_BASE = 8'hB0;
   localparam logic [7:0] PANEL_COL_HIGH  = 8'h10;
   localparam logic [7:0] PANEL_COL_LOW   = 8'h00;

   localparam logic [7:0] MAX_COLUMN = 8'd255;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] x_pos;
      logic [5:0] y_pos;
      logic [4:0] glyph_height;
      logic [7:0] glyph_byte;
      logic       ink;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_G_FETCH,
      ST_G_CAPT,
      ST_G_BIT,
      ST_G_WRITE,
      ST_R_READ,
      ST_R_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start_load;
      logic glyph_init;
      logic clear_init;
      logic clear_step;
      logic fetch;
      logic capture;
      logic bit_step;
      logic write_back;
      logic ref_read;
      logic ref_emit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_last;
      logic bit_last;
      logic page_end;
      logic byte_done;
      logic out_free;
   } dp_status_type;

endpackage

/* hw/rtl/mfgb_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module mfgb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/mfgb_ctrl.sv */
// Controller state machine that sequences glyph drawing, clearing and refresh.
module mfgb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_cmd,
   input  mfgb_pkg::dp_status_type status,
   output mfgb_pkg::dp_cmd_type    cmd
);
   import mfgb_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         // The store is swept to zero right after reset.
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_START:   state_in = ST_IDLE;
                  CMD_GLYPH:   state_in = ST_G_FETCH;
                  CMD_CLEAR:   state_in = ST_CLEAR;
                  CMD_REFRESH: state_in = ST_R_READ;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_G_FETCH: state_in = ST_G_CAPT;
         ST_G_CAPT:  state_in = ST_G_BIT;
         ST_G_BIT: begin
            if (status.bit_last || status.page_end) begin
               state_in = ST_G_WRITE;
            end
         end
         ST_G_WRITE: state_in = status.byte_done ? ST_IDLE : ST_G_FETCH;
         ST_R_READ:  state_in = ST_R_EMIT;
         ST_R_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.start_load = accept && (req_cmd == CMD_START);
            cmd.glyph_init = accept && (req_cmd == CMD_GLYPH);
            cmd.clear_init = accept && (req_cmd == CMD_CLEAR);
         end
         ST_CLEAR:   cmd.clear_step = 1'b1;
         ST_G_FETCH: cmd.fetch      = 1'b1;
         ST_G_CAPT:  cmd.capture    = 1'b1;
         ST_G_BIT:   cmd.bit_step   = 1'b1;
         ST_G_WRITE: cmd.write_back = 1'b1;
         ST_R_READ:  cmd.ref_read   = 1'b1;
         ST_R_EMIT:  cmd.ref_emit   = status.out_free;
         default:    cmd = '0;
      endcase
   end

   a_write_after_bits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_G_WRITE) |-> ($past(state_ff) == ST_G_BIT))
      else $error("page write-back not preceded by a bit step");

   a_capture_after_fetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_G_CAPT) |-> ($past(state_ff) == ST_G_FETCH))
      else $error("capture without a preceding fetch");

   a_emit_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_R_EMIT) |->
         (($past(state_ff) == ST_R_READ) || ($past(state_ff) == ST_R_EMIT)))
      else $error("refresh emit without a preceding read");

endmodule

/* hw/rtl/mfgb_datapath.sv */
// Datapath: glyph walk registers, page buffer, clear sweep and refresh output.
module mfgb_datapath #(
   parameter int COLUMNS    = 128,
   parameter int PAGES      = 4,
   parameter int MAX_HEIGHT = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mfgb_pkg::req_type                      req_data,
   input  mfgb_pkg::dp_cmd_type                   cmd,
   output mfgb_pkg::dp_status_type                status,
   output logic                                   ram_we,
   output logic [$clog2(COLUMNS*PAGES)-1:0]       ram_waddr,
   output logic [7:0]                             ram_wdata,
   output logic                                   ram_re,
   output logic [$clog2(COLUMNS*PAGES)-1:0]       ram_raddr,
   input  logic [7:0]                             ram_rdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output mfgb_pkg::rsp_type                      rsp_data
);
   import mfgb_pkg::*;

   localparam int ROWS   = PAGES * 8;
   localparam int STORE  = COLUMNS * PAGES;
   localparam int ADDR_W = $clog2(STORE);
   localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int IDX_W  = $clog2(COLUMNS + 3);
   localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(COLUMNS + 2);
   localparam logic [IDX_W-1:0]  IDX_DATA   = IDX_W'(3);
   localparam logic [PAGE_W-1:0] PAGE_LAST  = PAGE_W'(PAGES - 1);
   localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE - 1);
   localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
   localparam logic [5:0]        MAX_H      = 6'(MAX_HEIGHT);

   // Walk state.
   logic [7:0]        cur_col_ff, cur_col_in;
   logic [5:0]        base_row_ff, base_row_in;
   logic [4:0]        row_cnt_ff, row_cnt_in;
   logic [4:0]        col_h_ff, col_h_in;
   logic              ink_ff, ink_in;
   logic              byte_done_ff, byte_done_in;
   // Refresh position and clear sweep.
   logic [PAGE_W-1:0] ref_page_ff, ref_page_in;
   logic [IDX_W-1:0]  ref_idx_ff, ref_idx_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              fill_ff, fill_in;
   logic              rsp_valid_ff, rsp_valid_in;
   // Payload registers.
   logic [7:0]        bits_ff, bits_in;
   logic [2:0]        bit_cnt_ff, bit_cnt_in;
   logic [7:0]        buf_ff, buf_in;
   logic [ADDR_W-1:0] wb_addr_ff, wb_addr_in;
   logic              wb_ok_ff, wb_ok_in;
   rsp_type           rsp_ff, rsp_in;

   logic [6:0]        row_w;
   logic              in_store;
   logic [ADDR_W-1:0] pix_addr;
   logic [5:0]        row_next;
   logic              col_full;
   logic              pix_val;
   logic [IDX_W-1:0]  ref_col;
   logic [ADDR_W-1:0] ref_addr;
   logic [5:0]        gh_wide;

   assign row_w    = {1'b0, base_row_ff} + {2'b00, row_cnt_ff};
   assign in_store = (row_w < 7'(ROWS)) && ({1'b0, cur_col_ff} < 9'(COLUMNS));
   assign pix_addr = ADDR_W'(row_w[PAGE_W+2:3]) * COLS_A + ADDR_W'(cur_col_ff);
   assign row_next = {1'b0, row_cnt_ff} + 6'd1;
   assign col_full = (row_next >= {1'b0, col_h_ff});
   assign pix_val  = bits_ff[7] ? ink_ff : ~ink_ff;
   // Data bytes run from the last column down to column 0.
   assign ref_col  = IDX_LAST - ref_idx_ff;
   assign ref_addr = ADDR_W'(ref_page_ff) * COLS_A + ADDR_W'(ref_col);
   assign gh_wide  = {1'b0, req_data.glyph_height};

   assign status.sweep_last = (sweep_ff == SWEEP_LAST);
   assign status.bit_last   = col_full || (bit_cnt_ff == 3'd7);
   assign status.page_end   = (row_w[2:0] == 3'b111);
   assign status.byte_done  = byte_done_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign ram_we    = cmd.clear_step || (cmd.write_back && wb_ok_ff);
   assign ram_waddr = cmd.clear_step ? sweep_ff : wb_addr_ff;
   assign ram_wdata = cmd.clear_step ? {8{fill_ff}} : buf_ff;
   assign ram_re    = cmd.fetch || cmd.ref_read;
   assign ram_raddr = cmd.fetch ? pix_addr : ref_addr;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      cur_col_in   = cur_col_ff;
      base_row_in  = base_row_ff;
      row_cnt_in   = row_cnt_ff;
      col_h_in     = col_h_ff;
      ink_in       = ink_ff;
      byte_done_in = byte_done_ff;
      ref_page_in  = ref_page_ff;
      ref_idx_in   = ref_idx_ff;
      sweep_in     = sweep_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      bits_in      = bits_ff;
      bit_cnt_in   = bit_cnt_ff;
      buf_in       = buf_ff;
      wb_addr_in   = wb_addr_ff;
      wb_ok_in     = wb_ok_ff;
      rsp_in       = rsp_ff;

      if (cmd.start_load) begin
         cur_col_in  = req_data.x_pos;
         base_row_in = req_data.y_pos;
         row_cnt_in  = 5'd0;
         ink_in      = req_data.ink;
         priority if (gh_wide == 6'd0) begin
            col_h_in = 5'd1;
         end else if (gh_wide > MAX_H) begin
            col_h_in = MAX_H[4:0];
         end else begin
            col_h_in = req_data.glyph_height;
         end
      end

      if (cmd.glyph_init) begin
         bits_in      = req_data.glyph_byte;
         bit_cnt_in   = 3'd0;
         byte_done_in = 1'b0;
      end

      if (cmd.clear_init) begin
         fill_in = req_data.ink;
      end
      if (cmd.clear_step) begin
         sweep_in = status.sweep_last ? '0 : sweep_ff + ADDR_W'(1);
      end

      // The whole page shares one column, so one in-store flag covers it.
      if (cmd.fetch) begin
         wb_addr_in = pix_addr;
         wb_ok_in   = in_store;
      end
      if (cmd.capture) begin
         buf_in = ram_rdata;
      end

      if (cmd.bit_step) begin
         buf_in[3'd7 - row_w[2:0]] = pix_val;
         bits_in      = {bits_ff[6:0], 1'b0};
         bit_cnt_in   = bit_cnt_ff + 3'd1;
         byte_done_in = status.bit_last;
         if (col_full) begin
            row_cnt_in = 5'd0;
            if (cur_col_ff != MAX_COLUMN) begin
               cur_col_in = cur_col_ff + 8'd1;
            end
         end else begin
            row_cnt_in = row_next[4:0];
         end
      end

      if (cmd.ref_emit) begin
         rsp_in.is_data = (ref_idx_ff >= IDX_DATA);
         rsp_in.last    = 1'b0;
         priority if (ref_idx_ff == IDX_W'(0)) begin
            rsp_in.out_byte = PANEL_PAGE_BASE + 8'(PAGES - 1) - 8'(ref_page_ff);
         end else if (ref_idx_ff == IDX_W'(1)) begin
            rsp_in.out_byte = PANEL_COL_HIGH;
         end else if (ref_idx_ff == IDX_W'(2)) begin
            rsp_in.out_byte = PANEL_COL_LOW;
         end else begin
            rsp_in.out_byte = ram_rdata;
         end
         if (ref_idx_ff == IDX_LAST) begin
            ref_idx_in = '0;
            if (ref_page_ff == PAGE_LAST) begin
               ref_page_in = '0;
               rsp_in.last = 1'b1;
            end else begin
               ref_page_in = ref_page_ff + PAGE_W'(1);
            end
         end else begin
            ref_idx_in = ref_idx_ff + IDX_W'(1);
         end
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff   <= 8'd0;
         base_row_ff  <= 6'd0;
         row_cnt_ff   <= 5'd0;
         col_h_ff     <= 5'd8;
         ink_ff       <= 1'b1;
         byte_done_ff <= 1'b0;
         ref_page_ff  <= '0;
         ref_idx_ff   <= '0;
         sweep_ff     <= '0;
         fill_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_col_ff   <= cur_col_in;
         base_row_ff  <= base_row_in;
         row_cnt_ff   <= row_cnt_in;
         col_h_ff     <= col_h_in;
         ink_ff       <= ink_in;
         byte_done_ff <= byte_done_in;
         ref_page_ff  <= ref_page_in;
         ref_idx_ff   <= ref_idx_in;
         sweep_ff     <= sweep_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff    <= bits_in;
      bit_cnt_ff <= bit_cnt_in;
      buf_ff     <= buf_in;
      wb_addr_ff <= wb_addr_in;
      wb_ok_ff   <= wb_ok_in;
      rsp_ff     <= rsp_in;
   end

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

   a_row_in_column: assert property (@(posedge clock) disable iff (reset)
      (row_cnt_ff < col_h_ff) && (col_h_ff != 5'd0))
      else $error("row counter ran past the column height");

   a_ref_idx_range: assert property (@(posedge clock) disable iff (reset)
      cmd.ref_emit |=> (ref_idx_ff <= IDX_LAST))
      else $error("refresh index out of range");

endmodule

/* hw/rtl/mono_framebuffer_glyph_blitter_core.sv */
// Start loads position, height and ink on acceptance. A glyph byte fetches, captures, draws bits
// into and writes back each touched page. Clear writes one frame store word per cycle; requests
// wait until idle. Refresh reads in ST_R_READ and registers out in ST_R_EMIT once output is free.
// The single frame store port pair and the bit-serial page buffer set this pacing.
// Reset: synchronous, active high; afterwards a clearing pass writes all COLUMNS*PAGES words
// of the frame store to zero while no transaction is accepted.
module mono_framebuffer_glyph_blitter_core #(
   parameter int COLUMNS    = 128,
   parameter int PAGES      = 4,
   parameter int MAX_HEIGHT = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mfgb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mfgb_pkg::rsp_type rsp_data
);
   import mfgb_pkg::*;

   localparam int ADDR_W = $clog2(COLUMNS * PAGES);

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;

   mfgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .status    (status),
      .cmd       (cmd)
   );

   mfgb_datapath #(
      .COLUMNS    (COLUMNS),
      .PAGES      (PAGES),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   mfgb_ram #(
      .WIDTH (8),
      .DEPTH (COLUMNS * PAGES)
   ) u_frame_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule
